/* rtl/json_string_unescape_top_macros.svh */
// Assertion helpers for the top-level RTL; clk and rst_n must be in scope.
`ifndef JSON_STRING_UNESCAPE_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define JSU_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge forces the consequent at the next edge.
`define JSU_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

    localparam int MaxRes = 6;
    localparam int ResCntW = $clog2(MaxRes + 1);

    // result kinds (tuser)
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_TRUNC    = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd4;
    localparam logic [2:0] ERR_UNTERM   = 3'd5;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_STR  = 5'b00010,
        MODE_ESC  = 5'b00100,
        MODE_HEX  = 5'b01000,
        MODE_DROP = 5'b10000
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] acc;
        logic [1:0]  cnt;
        logic [9:0]  pend_bits;
        logic        pend_vld;
    } state_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
    } res_entry_t;

    typedef struct packed {
        logic [ResCntW-1:0]          cnt;
        res_entry_t [MaxRes-1:0]     ent;
    } res_list_t;

endpackage

`default_nettype wire

/* rtl/jsu_decode.sv */
`default_nettype none

module jsu_decode
(
    input  var jsu_pkg::state_t    st,
    input  wire logic [7:0]        in_byte,
    input  wire logic              eoi,
    output jsu_pkg::state_t        nxt,
    output jsu_pkg::res_list_t     lst
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] SurrHiBase = 16'hD800;
    localparam logic [20:0] SuppBase   = 21'h10000;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] chr;
    } esc_t;

    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t r;
        r.ok  = 1'b1;
        r.val = b[3:0];
        if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF))
            r.val = b[3:0] + 4'd9;
        else if (!(b >= CH_0 && b <= CH_9))
        begin
            r.ok  = 1'b0;
            r.val = '0;
        end
        return r;
    endfunction

    function automatic esc_t esc_map(input logic [7:0] b);
        esc_t r;
        r.ok = 1'b1;
        case (b)
            CH_QUOTE:  r.chr = CH_QUOTE;
            CH_BSLASH: r.chr = CH_BSLASH;
            CH_SLASH:  r.chr = CH_SLASH;
            CH_B:      r.chr = 8'h08;
            CH_F:      r.chr = 8'h0C;
            CH_N:      r.chr = 8'h0A;
            CH_R:      r.chr = 8'h0D;
            CH_T:      r.chr = 8'h09;
            default:
            begin
                r.ok  = 1'b0;
                r.chr = '0;
            end
        endcase
        return r;
    endfunction

    function automatic jsu_pkg::res_list_t push(input jsu_pkg::res_list_t l,
                                                input jsu_pkg::res_entry_t e);
        jsu_pkg::res_list_t r;
        r = l;
        if (l.cnt < jsu_pkg::ResCntW'(jsu_pkg::MaxRes))
        begin
            r.ent[l.cnt] = e;
            r.cnt        = l.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic jsu_pkg::res_entry_t mk_byte(input logic [7:0] b);
        jsu_pkg::res_entry_t e;
        e.data = b;
        e.kind = jsu_pkg::KIND_BYTE;
        e.code = jsu_pkg::ERR_NONE;
        return e;
    endfunction

    // UTF-8 encode one code point into 1..4 entries
    function automatic jsu_pkg::res_list_t push_cp(input jsu_pkg::res_list_t l,
                                                   input logic [20:0] cp);
        jsu_pkg::res_list_t r;
        r = l;
        if (cp < 21'h80)
            r = push(r, mk_byte(cp[7:0]));
        else if (cp < 21'h800)
        begin
            r = push(r, mk_byte({3'b110, cp[10:6]}));
            r = push(r, mk_byte({2'b10, cp[5:0]}));
        end
        else if (cp < SuppBase)
        begin
            r = push(r, mk_byte({4'b1110, cp[15:12]}));
            r = push(r, mk_byte({2'b10, cp[11:6]}));
            r = push(r, mk_byte({2'b10, cp[5:0]}));
        end
        else
        begin
            r = push(r, mk_byte({5'b11110, cp[20:18]}));
            r = push(r, mk_byte({2'b10, cp[17:12]}));
            r = push(r, mk_byte({2'b10, cp[11:6]}));
            r = push(r, mk_byte({2'b10, cp[5:0]}));
        end
        return r;
    endfunction

    function automatic logic [20:0] high_cp(input logic [9:0] bits);
        return {5'd0, SurrHiBase[15:10], bits};
    endfunction

    hex_t                 hex;
    esc_t                 esc;
    logic [15:0]          acc_n;
    logic                 fail_en;
    logic [2:0]           fail_code;
    jsu_pkg::res_entry_t  err_ent;

    always_comb
    begin
        nxt       = st;
        lst       = '0;
        fail_en   = 1'b0;
        fail_code = jsu_pkg::ERR_NONE;
        hex       = hex_value(in_byte);
        esc       = esc_map(in_byte);
        acc_n     = {st.acc[11:0], hex.val};

        case (st.mode)
            jsu_pkg::MODE_STR:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    if (eoi)
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_TRUNC;
                    end
                    else
                        nxt.mode = jsu_pkg::MODE_ESC;
                end
                else
                begin
                    if (st.pend_vld)
                        lst = push_cp(lst, high_cp(st.pend_bits));
                    nxt.pend_vld  = 1'b0;
                    nxt.pend_bits = '0;
                    if (in_byte == CH_QUOTE)
                    begin
                        lst      = push(lst, '{data: 8'd0, kind: jsu_pkg::KIND_DONE,
                                                code: jsu_pkg::ERR_NONE});
                        nxt.mode = jsu_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        lst = push(lst, mk_byte(in_byte));
                        if (eoi)
                        begin
                            fail_en   = 1'b1;
                            fail_code = jsu_pkg::ERR_UNTERM;
                        end
                    end
                end
            end
            jsu_pkg::MODE_ESC:
            begin
                if (in_byte == CH_U)
                begin
                    nxt.acc = '0;
                    nxt.cnt = '0;
                    if (eoi)
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_HEX;
                    end
                    else
                        nxt.mode = jsu_pkg::MODE_HEX;
                end
                else
                begin
                    if (st.pend_vld)
                        lst = push_cp(lst, high_cp(st.pend_bits));
                    nxt.pend_vld  = 1'b0;
                    nxt.pend_bits = '0;
                    if (!esc.ok)
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_ESC;
                    end
                    else
                    begin
                        lst      = push(lst, mk_byte(esc.chr));
                        nxt.mode = jsu_pkg::MODE_STR;
                        if (eoi)
                        begin
                            fail_en   = 1'b1;
                            fail_code = jsu_pkg::ERR_UNTERM;
                        end
                    end
                end
            end
            jsu_pkg::MODE_HEX:
            begin
                if (!hex.ok)
                begin
                    fail_en   = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_HEX;
                end
                else if (st.cnt == 2'd3)
                begin
                    nxt.acc  = acc_n;
                    nxt.cnt  = '0;
                    nxt.mode = jsu_pkg::MODE_STR;
                    if (st.pend_vld)
                    begin
                        // held-back digits guarantee acc_n is a low surrogate
                        lst = push_cp(lst, SuppBase + 21'({st.pend_bits, acc_n[9:0]}));
                        nxt.pend_vld  = 1'b0;
                        nxt.pend_bits = '0;
                    end
                    else if (acc_n[15:10] == SurrHiBase[15:10] && !eoi)
                    begin
                        nxt.pend_bits = acc_n[9:0];
                        nxt.pend_vld  = 1'b1;
                    end
                    else
                        lst = push_cp(lst, {5'd0, acc_n});
                    if (eoi)
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_UNTERM;
                    end
                end
                else
                begin
                    // release the high surrogate once no low one can follow
                    if (st.pend_vld &&
                        ((st.cnt == 2'd0 && acc_n != 16'h000D) ||
                         (st.cnt == 2'd1 && acc_n < 16'h00DC)))
                    begin
                        lst           = push_cp(lst, high_cp(st.pend_bits));
                        nxt.pend_vld  = 1'b0;
                        nxt.pend_bits = '0;
                    end
                    nxt.acc = acc_n;
                    nxt.cnt = st.cnt + 2'd1;
                    if (eoi)
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_HEX;
                    end
                end
            end
            jsu_pkg::MODE_DROP:
            begin
                if (eoi)
                    nxt.mode = jsu_pkg::MODE_IDLE;
            end
            default:
            begin
                nxt.pend_vld  = 1'b0;
                nxt.pend_bits = '0;
                nxt.cnt       = '0;
                nxt.acc       = '0;
                if (in_byte == CH_QUOTE)
                begin
                    if (eoi)
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_UNTERM;
                    end
                    else
                        nxt.mode = jsu_pkg::MODE_STR;
                end
                else
                begin
                    fail_en   = 1'b1;
                    fail_code = jsu_pkg::ERR_NO_QUOTE;
                end
            end
        endcase

        err_ent.data = 8'd0;
        err_ent.kind = jsu_pkg::KIND_ERROR;
        err_ent.code = fail_code;

        // any surrogate still held goes out ahead of the error
        if (fail_en)
        begin
            if (nxt.pend_vld)
                lst = push_cp(lst, high_cp(nxt.pend_bits));
            lst      = push(lst, err_ent);
            nxt.mode = eoi ? jsu_pkg::MODE_IDLE : jsu_pkg::MODE_DROP;
            nxt.cnt  = '0;
        end

        if (nxt.mode == jsu_pkg::MODE_IDLE || nxt.mode == jsu_pkg::MODE_DROP)
        begin
            nxt.pend_vld  = 1'b0;
            nxt.pend_bits = '0;
        end
    end

endmodule

`default_nettype wire

/* rtl/jsu_res_queue.sv */
`default_nettype none

module jsu_res_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  var jsu_pkg::res_list_t    lst,
    output logic                      can_load,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output jsu_pkg::res_entry_t       out_ent,
    output logic                      out_last
);

    localparam int CntW = jsu_pkg::ResCntW;

    jsu_pkg::res_entry_t [jsu_pkg::MaxRes-1:0] ent_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic            busy;
    logic            pop;

    assign busy      = (idx_reg != cnt_reg);
    assign out_last  = busy && ((idx_reg + 1'b1) == cnt_reg);
    assign pop       = busy && out_ready;
    assign can_load  = !busy || (pop && out_last);
    assign out_valid = busy;
    assign out_ent   = busy ? ent_reg[idx_reg] : '0;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = lst.cnt;
            idx_next = '0;
        end
        else if (pop)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ent_reg <= lst.ent;
    end

endmodule

`default_nettype wire

/* rtl/json_string_unescape_top.sv */
// JSON string unescaper.
// Input stream: one raw byte per transaction on s_tdata, s_tlast marks the
// last byte of the buffer. Output stream: one result per transaction;
// m_tuser gives the kind (content byte, string closed, error), m_tdata holds
// the byte and the error code, m_tlast marks the final result of one input byte.
// An input byte lands in an input register and is decoded there into a list of
// 0 to 6 results, which is loaded into the result register once that register
// can take it. The first result of a byte is presented once its list has been
// loaded into the result register.
// Throughput: one byte per cycle while each byte yields at most one result and
// m_tready stays high; a byte yielding N results (UTF-8 sequences, flushed
// surrogates, errors) holds the result register until its N results have left
// through the one-result-per-cycle output port.
// When the receiver stalls, one further byte is taken into the input register,
// then s_tready drops until the pending result list drains.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser
// to idle, waiting for an opening quote.
`default_nettype none
`include "json_string_unescape_top_macros.svh"

module json_string_unescape_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] error_code, [15:11] zero
    output logic [1:0]       m_tuser,   // [1:0] result_kind
    output logic             m_tlast
);

    logic                 in_vld_reg, in_vld_next;
    logic [7:0]           in_byte_reg;
    logic                 eoi_reg;
    jsu_pkg::state_t      st_reg;
    jsu_pkg::state_t      st_next;
    jsu_pkg::res_list_t   lst;
    jsu_pkg::res_entry_t  out_ent;
    logic                 q_ready;
    logic                 take;
    logic                 s_hs;
    logic                 in_string;
    logic                 in_hex;
    logic                 nonbyte_data;

    assign take     = in_vld_reg && q_ready;
    assign s_tready = !in_vld_reg || q_ready;
    assign s_hs     = s_tvalid && s_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_hs)
            in_vld_next = 1'b1;
        else if (take)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg         <= 1'b0;
            st_reg.mode        <= jsu_pkg::MODE_IDLE;
            st_reg.acc         <= '0;
            st_reg.cnt         <= '0;
            st_reg.pend_bits   <= '0;
            st_reg.pend_vld    <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (take)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_hs)
        begin
            in_byte_reg <= s_tdata;
            eoi_reg     <= s_tlast;
        end
    end

    jsu_decode u_decode
    (
        .st      (st_reg),
        .in_byte (in_byte_reg),
        .eoi     (eoi_reg),
        .nxt     (st_next),
        .lst     (lst)
    );

    jsu_res_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .lst       (lst),
        .can_load  (q_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ent   (out_ent),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'd0, out_ent.code, out_ent.data};
    assign m_tuser = out_ent.kind;

    assign in_string    = st_reg.mode == jsu_pkg::MODE_STR || st_reg.mode == jsu_pkg::MODE_ESC ||
                          st_reg.mode == jsu_pkg::MODE_HEX;
    assign in_hex       = st_reg.mode == jsu_pkg::MODE_HEX;
    assign nonbyte_data = m_tvalid && m_tuser != jsu_pkg::KIND_BYTE && m_tdata[7:0] != 8'd0;

    `JSU_CHECK(a_pend_in_string, !st_reg.pend_vld || in_string, "surrogate held outside string")
    `JSU_CHECK(a_hex_cnt_mode, st_reg.cnt == 2'd0 || in_hex, "hex count outside hex escape")
    `JSU_CHECK(a_nonbyte_zero, !nonbyte_data, "non-byte result carries data")
    `JSU_CHECK_NEXT(a_inreg_drains, take && !s_hs, !in_vld_reg, "input register kept after load")

endmodule

`default_nettype wire
